// ===== rtl/core/erl_pkg.sv =====
`default_nettype none
package erl_pkg;
   localparam int KeySlots = 8;
   localparam int SlotBits = (KeySlots > 1) ? $clog2(KeySlots) : 1;
   localparam int SlotCntBits = $clog2(KeySlots + 1);
   localparam logic [21:0] HourMs = 22'd3600000;
   localparam logic [9:0] TokenMilli = 10'd1000;
   // Ceiling of 2^32 / 225, exact for dividends below 2^24.
   localparam logic [24:0] Recip225 = 25'd19088744;

   localparam logic [1:0] ReasonPass = 2'd0;
   localparam logic [1:0] ReasonLowSev = 2'd1;
   localparam logic [1:0] ReasonDup = 2'd2;
   localparam logic [1:0] ReasonEmpty = 2'd3;

   localparam logic [1:0] RegKeyHold = 2'd0;
   localparam logic [1:0] RegRate = 2'd1;
   localparam logic [1:0] RegMinSev = 2'd2;

   typedef struct packed {
      logic        used;
      logic [15:0] code;
      logic [7:0]  valve;
      logic [31:0] stamp;
   } slot_type;

   typedef struct packed {
      logic [31:0] key_hold;
      logic [15:0] rate;
      logic [2:0]  min_sev;
   } cfg_type;
endpackage
`default_nettype wire

// ===== rtl/core/event_rate_limiter_top.sv =====
`default_nettype none
// Token-bucket event limiter with a table of recently passed keys. Each event
// yields one result beat. An event passes in turn through the refill pipeline
// (division by 3600000 through reciprocal multiplication), a hand-over, a scan
// that reads each key slot in turn from the slot memory, a decide step, a send
// step and the result handshake. The next event is accepted only after the
// result beat has been taken, so a stalled receiver stalls the input.
// Registers: 0 key hold ms, 1 events per hour (writing it refills the bucket),
// 2 minimum severity.
module event_rate_limiter_top
   import erl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // now_ms, event_code, valve, severity
   input  wire logic        req_tuser,   // calibration_outcome
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // allowed, drop_reason, suppressed_total
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   cfg_type cfg_ff;
   logic wr;
   logic [34:0] od;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{32'd60000, 16'd60, 3'd2};
      end else if (wr) begin
         case (csr_paddr[3:2])
            RegKeyHold: cfg_ff.key_hold <= csr_pwdata;
            RegRate: cfg_ff.rate <= csr_pwdata[15:0];
            RegMinSev: cfg_ff.min_sev <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         RegKeyHold: csr_prdata = cfg_ff.key_hold;
         RegRate: csr_prdata = {16'd0, cfg_ff.rate};
         RegMinSev: csr_prdata = {29'd0, cfg_ff.min_sev};
         default: csr_prdata = '0;
      endcase
   end

   erl_core u_core (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .rate_wr(wr && csr_paddr[3:2] == RegRate), .rate_new(csr_pwdata[15:0]),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data({req_tuser, req_tdata[58:0]}),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(od)
   );
   assign rsp_tdata = {5'd0, od};
endmodule
`default_nettype wire

// ===== rtl/core/erl_refill.sv =====
`default_nettype none
// Bucket refill in a pipeline. The elapsed time is split into whole
// periods of 3600 ms and a rest, so dividing elapsed * rate * 1000 + carry by
// 3600000 reduces to two divisions by 3600 and one conditional subtraction.
// An elapsed time of an hour or more always fills the bucket.
module erl_refill
   import erl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] elapsed,
   input  wire logic [15:0] rate,
   input  wire logic [21:0] carry,
   output logic             done,
   output logic [41:0]      quotient,
   output logic [21:0]      remainder
);
   logic [5:0]  vld_ff;
   logic [21:0] e_ff;
   logic        sat_ff;
   logic [15:0] rate_ff;
   logic [21:0] carry_ff;
   logic [10:0] e1_ff;
   logic [11:0] e0_ff;
   logic [26:0] e1r_ff;
   logic [27:0] x2_ff;
   logic [16:0] q2_ff;
   logic [11:0] r2_ff;
   logic [26:0] qs_ff;
   logic [22:0] t_ff;
   logic [41:0] quo_ff;
   logic [21:0] rem_ff;
   logic [16:0] e1_full;
   logic [16:0] q2_full;
   logic [21:0] e0_full;
   logic [27:0] r2_full;
   logic [22:0] t_sub;
   logic        t_wrap;

   // x / 3600 is (x / 16) / 225, the latter by reciprocal multiplication.
   function automatic logic [16:0] div3600(input logic [27:0] x);
      logic [48:0] p;
      p = {25'd0, x[27:4]} * {24'd0, Recip225};
      return p[48:32];
   endfunction

   assign e1_full = div3600({6'd0, elapsed[21:0]});
   assign e0_full = e_ff - {11'd0, e1_ff} * 22'd3600;
   assign q2_full = div3600(x2_ff);
   assign r2_full = x2_ff - {11'd0, q2_ff} * 28'd3600;
   assign t_sub = t_ff - {1'b0, HourMs};
   assign t_wrap = t_ff >= {1'b0, HourMs};
   assign quotient = quo_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         done <= 1'b0;
      end else begin
         vld_ff <= {vld_ff[4:0], start};
         done <= vld_ff[5];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         e_ff <= elapsed[21:0];
         sat_ff <= elapsed >= {10'd0, HourMs};
         rate_ff <= rate;
         carry_ff <= carry;
         e1_ff <= e1_full[10:0];
      end
      e0_ff <= e0_full[11:0];
      e1r_ff <= {16'd0, e1_ff} * {11'd0, rate_ff};
      x2_ff <= {16'd0, e0_ff} * {12'd0, rate_ff};
      q2_ff <= q2_full;
      r2_ff <= r2_full[11:0];
      qs_ff <= e1r_ff + {10'd0, q2_ff};
      t_ff <= {11'd0, r2_ff} * {13'd0, TokenMilli} + {1'b0, carry_ff};
      if (vld_ff[5]) begin
         quo_ff <= sat_ff ? '1 : {15'd0, qs_ff} + {41'd0, t_wrap};
         rem_ff <= t_wrap ? t_sub[21:0] : t_ff[21:0];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/erl_core.sv =====
`default_nettype none
// Sequencer around the key slot memory: one slot read per cycle for expiry,
// match and victim choice, then, if the event passes, a single write of the chosen slot.
module erl_core
   import erl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        rate_wr,
   input  wire logic [15:0] rate_new,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [59:0] in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [34:0]      out_data
);
   typedef enum logic [2:0] {IDLE, REFILL, SCAN, DECIDE, SEND} state_type;
   state_type state_ff;

   slot_type mem [KeySlots];
   logic [KeySlots-1:0] used_ff;
   slot_type rd_ff;
   logic [SlotBits-1:0] rd_idx_ff;

   logic [31:0] now_ff, last_ff, cnt_sup_ff, best_age_ff;
   logic [15:0] code_ff;
   logic [7:0]  valve_ff;
   logic [2:0]  sev_ff;
   logic        calib_ff, dup_ff, free_ff, rd_v_ff;
   logic [25:0] tokens_ff;
   logic [21:0] carry_ff;
   logic [SlotBits-1:0] pick_ff, scan_ff;
   logic [SlotCntBits-1:0] seen_ff;
   logic        allowed_ff;
   logic [1:0]  reason_ff;
   logic        start_ff;

   logic        ref_done;
   logic [41:0] ref_q;
   logic [21:0] ref_r;
   logic [25:0] cap;
   logic [25:0] new_cap;
   logic [42:0] tok_sum;
   logic [31:0] age;
   logic        live;

   assign cap = {10'd0, cfg.rate} * {16'd0, TokenMilli};
   // The rate register takes the new value at the same edge, so the new
   // capacity comes from the written data.
   assign new_cap = {10'd0, rate_new} * {16'd0, TokenMilli};
   assign tok_sum = {17'd0, tokens_ff} + {1'b0, ref_q};
   assign age = now_ff - rd_ff.stamp;
   assign live = used_ff[rd_idx_ff] && (age >= cfg.key_hold ? 1'b0 : 1'b1);

   erl_refill u_refill (
      .clock(clock), .reset(reset), .start(start_ff), .elapsed(now_ff - last_ff),
      .rate(cfg.rate), .carry(carry_ff), .done(ref_done), .quotient(ref_q),
      .remainder(ref_r)
   );

   assign in_ready = (state_ff == IDLE) && !out_valid;

   always_ff @(posedge clock) begin
      rd_ff <= mem[scan_ff];
      rd_idx_ff <= scan_ff;
      if (state_ff == DECIDE && reason_ff == ReasonPass && !dup_ff
          && tokens_ff >= 26'(TokenMilli)) begin
         mem[pick_ff] <= '{1'b1, code_ff, valve_ff, now_ff};
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
         used_ff <= '0;
         tokens_ff <= 26'd60000;
         carry_ff <= '0;
         last_ff <= '0;
         cnt_sup_ff <= '0;
         out_valid <= 1'b0;
      end else begin
         if (out_valid && out_ready) out_valid <= 1'b0;
         if (rate_wr) begin
            tokens_ff <= new_cap;
            carry_ff <= '0;
         end
         case (state_ff)
            IDLE: begin
               if (in_valid && in_ready) begin
                  {calib_ff, sev_ff, valve_ff, code_ff, now_ff} <= in_data;
                  start_ff <= 1'b1;
                  state_ff <= REFILL;
               end
            end
            REFILL: begin
               if (ref_done) begin
                  last_ff <= now_ff;
                  if (tok_sum >= {17'd0, cap}) begin
                     tokens_ff <= cap;
                     carry_ff <= '0;
                  end else begin
                     tokens_ff <= tok_sum[25:0];
                     carry_ff <= ref_r;
                  end
                  scan_ff <= '0;
                  seen_ff <= '0;
                  rd_v_ff <= 1'b0;
                  dup_ff <= 1'b0;
                  free_ff <= 1'b0;
                  pick_ff <= '0;
                  best_age_ff <= '0;
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (scan_ff != SlotBits'(KeySlots - 1)) scan_ff <= scan_ff + 1'b1;
               rd_v_ff <= 1'b1;
               if (rd_v_ff) begin
                  seen_ff <= seen_ff + 1'b1;
                  if (!live) used_ff[rd_idx_ff] <= 1'b0;
                  if (live && rd_ff.code == code_ff && rd_ff.valve == valve_ff)
                     dup_ff <= 1'b1;
                  if (!free_ff) begin
                     if (!live) begin
                        free_ff <= 1'b1;
                        pick_ff <= rd_idx_ff;
                     end else if (seen_ff == '0 || age > best_age_ff) begin
                        pick_ff <= rd_idx_ff;
                        best_age_ff <= age;
                     end
                  end
                  if (seen_ff == SlotCntBits'(KeySlots - 1)) begin
                     reason_ff <= (sev_ff < cfg.min_sev && !calib_ff) ? ReasonLowSev
                                                                        : ReasonPass;
                     state_ff <= DECIDE;
                  end
               end
            end
            DECIDE: begin
               if (reason_ff == ReasonPass) begin
                  if (dup_ff) begin
                     reason_ff <= ReasonDup;
                     cnt_sup_ff <= cnt_sup_ff + 32'd1;
                  end else if (tokens_ff < 26'(TokenMilli)) begin
                     reason_ff <= ReasonEmpty;
                     cnt_sup_ff <= cnt_sup_ff + 32'd1;
                  end else begin
                     tokens_ff <= tokens_ff - 26'(TokenMilli);
                     used_ff[pick_ff] <= 1'b1;
                  end
               end
               state_ff <= SEND;
            end
            SEND: begin
               allowed_ff <= (reason_ff == ReasonPass);
               out_valid <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign out_data = {cnt_sup_ff, reason_ff, allowed_ff};

`ifndef SYNTH
   a_carry: assert property (@(posedge clock) disable iff (reset)
      carry_ff < HourMs) else $error("refill carry out of range");
   a_tok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE) |-> tokens_ff <= cap) else $error("bucket above capacity");
   a_hs: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> state_ff == REFILL) else $error("accept lost");
`endif
endmodule
`default_nettype wire
